// File: rtl/tis_pkg.sv
package tis_pkg;

  // vertex coordinate and derived widths
  localparam int unsigned CoordW  = 26;
  localparam int unsigned EdgeW   = CoordW + 1;       // signed edge component
  localparam int unsigned ProdW   = 2 * EdgeW;        // signed 2x2 product
  localparam int unsigned CofW    = 2 * EdgeW;        // signed cofactor
  localparam int unsigned DetW    = 82;               // signed exact determinant
  localparam int unsigned InvW    = 32;
  localparam int unsigned DetOutW = 64;
  localparam int unsigned Lanes   = 9;

  localparam int unsigned CoordFracBitsDef = 8;
  localparam int unsigned InvFracBitsDef   = 40;

  typedef struct packed {
    logic [CoordW-1:0] ref_x;
    logic [CoordW-1:0] ref_y;
    logic [CoordW-1:0] ref_z;
    logic [CoordW-1:0] second_x;
    logic [CoordW-1:0] second_y;
    logic [CoordW-1:0] second_z;
    logic [CoordW-1:0] third_x;
    logic [CoordW-1:0] third_y;
    logic [CoordW-1:0] third_z;
    logic [CoordW-1:0] fourth_x;
    logic [CoordW-1:0] fourth_y;
    logic [CoordW-1:0] fourth_z;
  } tis_in_t;

  typedef struct packed {
    logic signed [InvW-1:0]    inv_00;
    logic signed [InvW-1:0]    inv_01;
    logic signed [InvW-1:0]    inv_02;
    logic signed [InvW-1:0]    inv_10;
    logic signed [InvW-1:0]    inv_11;
    logic signed [InvW-1:0]    inv_12;
    logic signed [InvW-1:0]    inv_20;
    logic signed [InvW-1:0]    inv_21;
    logic signed [InvW-1:0]    inv_22;
    logic signed [DetOutW-1:0] determinant;
    logic                      degenerate;
  } tis_out_t;

  // side information that rides with each item through the divider
  typedef struct packed {
    logic                      deg;
    logic signed [DetOutW-1:0] det;
    logic [Lanes-1:0]          neg;
    logic [Lanes-1:0]          ovf;
  } tis_meta_t;

endpackage

// File: rtl/tis_cofactor.sv
module tis_cofactor import tis_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [EdgeW-1:0] e_i   [3][3],
  output logic                    valid_o,
  output logic signed [EdgeW-1:0] e0_o  [3],
  output logic signed [CofW-1:0]  cof_o [3][3]
);

  logic                    v1_q, v2_q;
  logic signed [ProdW-1:0] pa_q [3][3];
  logic signed [ProdW-1:0] pb_q [3][3];
  logic signed [EdgeW-1:0] e0a_q [3];
  logic signed [EdgeW-1:0] e0b_q [3];
  logic signed [CofW-1:0]  cof_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e0a_q[i] <= e_i[0][i];
        e0b_q[i] <= e0a_q[i];
      end
    end
    for (genvar j = 0; j < 3; j++) begin : g_col
      // 2x2 minor products of the cyclic cofactor
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pa_q[i][j] <= ProdW'(e_i[(i+1)%3][(j+1)%3]) * ProdW'(e_i[(i+2)%3][(j+2)%3]);
          pb_q[i][j] <= ProdW'(e_i[(i+1)%3][(j+2)%3]) * ProdW'(e_i[(i+2)%3][(j+1)%3]);
          cof_q[i][j] <= CofW'(pa_q[i][j] - pb_q[i][j]);
        end
      end
      assign cof_o[i][j] = cof_q[i][j];
    end
    assign e0_o[i] = e0b_q[i];
  end

  assign valid_o = v2_q;

endmodule

// File: rtl/tis_det.sv
module tis_det import tis_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [EdgeW-1:0] e0_i  [3],
  input  logic signed [CofW-1:0]  cof_i [3][3],
  output logic                    valid_o,
  output logic [DetW-1:0]         dmag_o,
  output logic [CofW-1:0]         mag_o [Lanes],
  output tis_meta_t               meta_o
);

  logic                   va_q, vb_q, vc_q;
  logic signed [DetW-1:0] pl_q [3];
  logic signed [DetW-1:0] ph_q [3];
  logic signed [CofW-1:0] cofa_q [3][3];
  logic signed [CofW-1:0] cofb_q [3][3];
  logic signed [DetW-1:0] det_q;
  logic signed [DetW-1:0] det_d;
  logic [DetW-1:0]        dmag_q;
  logic [CofW-1:0]        mag_q [Lanes];
  tis_meta_t              meta_q, meta_d;
  logic                   dneg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // first row expansion, cofactor split in a low unsigned and a high signed half
  for (genvar j = 0; j < 3; j++) begin : g_part
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pl_q[j] <= DetW'(e0_i[j]) * DetW'(signed'({1'b0, cof_i[0][j][EdgeW-1:0]}));
        ph_q[j] <= DetW'(e0_i[j]) * DetW'(signed'(cof_i[0][j][CofW-1:EdgeW]));
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ci
    for (genvar j = 0; j < 3; j++) begin : g_cj
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          cofa_q[i][j] <= cof_i[i][j];
          cofb_q[i][j] <= cofa_q[i][j];
        end
      end
    end
  end

  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (ph_q[j] <<< EdgeW) + pl_q[j];
    end
  end

  assign dneg = det_q[DetW-1];

  always_comb begin
    meta_d.deg = (det_q == '0);
    if (det_q[DetW-1:DetOutW-1] == '0 || det_q[DetW-1:DetOutW-1] == '1) begin
      meta_d.det = det_q[DetOutW-1:0];
    end else if (dneg) begin
      meta_d.det = {1'b1, {(DetOutW-1){1'b0}}};
    end else begin
      meta_d.det = {1'b0, {(DetOutW-1){1'b1}}};
    end
    meta_d.ovf = '0;
    for (int l = 0; l < Lanes; l++) begin
      meta_d.neg[l] = cofb_q[l%3][l/3][CofW-1] ^ dneg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q  <= det_d;
      dmag_q <= dneg ? DetW'(-det_q) : DetW'(det_q);
      meta_q <= meta_d;
    end
  end

  // lane 3*row+col takes the transposed cofactor
  for (genvar l = 0; l < Lanes; l++) begin : g_mag
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q[l] <= cofb_q[l%3][l/3][CofW-1] ? CofW'(-cofb_q[l%3][l/3])
                                              : CofW'(cofb_q[l%3][l/3]);
      end
    end
    assign mag_o[l] = mag_q[l];
  end

  assign valid_o = vc_q;
  assign dmag_o  = dmag_q;
  assign meta_o  = meta_q;

endmodule

// File: rtl/tis_divider.sv
module tis_divider import tis_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = CoordFracBitsDef,
  parameter int unsigned INV_FRAC_BITS   = InvFracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DetW-1:0]  dmag_i,
  input  logic [CofW-1:0]  mag_i [Lanes],
  input  tis_meta_t        meta_i,
  output logic             valid_o,
  output logic [InvW-1:0]  quo_o [Lanes],
  output tis_meta_t        meta_o
);

  localparam int unsigned Shift = INV_FRAC_BITS + COORD_FRAC_BITS;
  localparam int unsigned NumW  = CofW + Shift;
  localparam int unsigned HiW   = NumW - InvW;
  localparam int unsigned CmpW  = (HiW > DetW) ? HiW : DetW;
  localparam int unsigned RemW  = DetW + 1;
  localparam int unsigned Stg   = InvW + 1;

  logic            v_q    [Stg];
  logic [DetW-1:0] dmag_q [Stg];
  tis_meta_t       meta_q [Stg];
  logic [RemW-1:0] rem_q  [Stg][Lanes];
  logic [InvW-1:0] nlo_q  [Stg][Lanes];
  logic [InvW-1:0] quo_q  [Stg][Lanes];
  logic [Lanes-1:0] ovf_d;
  tis_meta_t       meta_d;

  // set-up stage: quotient range check and initial partial remainder
  for (genvar l = 0; l < Lanes; l++) begin : g_prep
    logic [NumW-1:0] num;
    logic [HiW-1:0]  hi;
    assign num = NumW'(mag_i[l]) << Shift;
    assign hi  = num[NumW-1:InvW];
    assign ovf_d[l] = CmpW'(hi) >= CmpW'(dmag_i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][l] <= RemW'(hi);
        nlo_q[0][l] <= num[InvW-1:0];
        quo_q[0][l] <= '0;
      end
    end
  end

  always_comb begin
    meta_d     = meta_i;
    meta_d.ovf = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q[0] <= dmag_i;
      meta_q[0] <= meta_d;
    end
  end

  // one restoring quotient bit per stage
  for (genvar s = 1; s < Stg; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dmag_q[s] <= dmag_q[s-1];
        meta_q[s] <= meta_q[s-1];
      end
    end
    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [RemW-1:0] trial;
      logic            ge;
      assign trial = {rem_q[s-1][l][DetW-1:0], nlo_q[s-1][l][InvW-1]};
      assign ge    = trial >= {1'b0, dmag_q[s-1]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s][l] <= ge ? trial - {1'b0, dmag_q[s-1]} : trial;
          nlo_q[s][l] <= {nlo_q[s-1][l][InvW-2:0], 1'b0};
          quo_q[s][l] <= {quo_q[s-1][l][InvW-2:0], ge};
        end
      end
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_out
    assign quo_o[l] = quo_q[Stg-1][l];
  end

  assign valid_o = v_q[Stg-1];
  assign meta_o  = meta_q[Stg-1];

endmodule

// File: rtl/tetrahedron_inverse_setup.sv
// tetrahedron inverse setup: takes one tetrahedron per request (four corners,
// unsigned fixed point) and returns the determinant of the edge matrix built
// from the three corners minus the reference corner, together with the nine
// entries of its inverse scaled by 2^INV_FRAC_BITS, truncated toward zero and
// saturated to 32 bits; a zero determinant raises degenerate and zeroes every
// other field. one request enters per cycle while no valid result is held by a
// stalled output; it then passes through the edge differences, the cofactors,
// the determinant (its 27 by 54 bit products are cut in two halves), the
// quotient range check and the restoring divider, one quotient bit per stage,
// then the output register. the whole pipeline holds while a valid output is
// stalled, so nothing is dropped or repeated.
module tetrahedron_inverse_setup import tis_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = CoordFracBitsDef,
  parameter int unsigned INV_FRAC_BITS   = InvFracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tis_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tis_out_t out_res_o
);

  // pipeline advance: only a held result stops everything
  logic en;
  logic out_valid_q;
  tis_out_t res_q, res_d;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // edge matrix, column c is corner c+1 minus the reference
  logic                    e_valid_q;
  logic signed [EdgeW-1:0] e_q [3][3];
  logic [CoordW-1:0]       ref_c [3];
  logic [CoordW-1:0]       vtx_c [3][3];

  assign ref_c[0] = in_req_i.ref_x;
  assign ref_c[1] = in_req_i.ref_y;
  assign ref_c[2] = in_req_i.ref_z;
  assign vtx_c[0][0] = in_req_i.second_x;
  assign vtx_c[1][0] = in_req_i.second_y;
  assign vtx_c[2][0] = in_req_i.second_z;
  assign vtx_c[0][1] = in_req_i.third_x;
  assign vtx_c[1][1] = in_req_i.third_y;
  assign vtx_c[2][1] = in_req_i.third_z;
  assign vtx_c[0][2] = in_req_i.fourth_x;
  assign vtx_c[1][2] = in_req_i.fourth_y;
  assign vtx_c[2][2] = in_req_i.fourth_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= in_valid_i;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_er
    for (genvar c = 0; c < 3; c++) begin : g_ec
      always_ff @(posedge clk_i) begin
        if (en) begin
          e_q[r][c] <= signed'({1'b0, vtx_c[r][c]}) - signed'({1'b0, ref_c[r]});
        end
      end
    end
  end

  // cofactors
  logic                    cof_valid;
  logic signed [EdgeW-1:0] e0_row [3];
  logic signed [CofW-1:0]  cof [3][3];

  tis_cofactor u_cofactor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_valid_q),
    .e_i     (e_q),
    .valid_o (cof_valid),
    .e0_o    (e0_row),
    .cof_o   (cof)
  );

  // determinant, its magnitude and the cofactor magnitudes per lane
  logic            det_valid;
  logic [DetW-1:0] dmag;
  logic [CofW-1:0] mag [Lanes];
  tis_meta_t       det_meta;

  tis_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cof_valid),
    .e0_i    (e0_row),
    .cof_i   (cof),
    .valid_o (det_valid),
    .dmag_o  (dmag),
    .mag_o   (mag),
    .meta_o  (det_meta)
  );

  // nine lanes of pipelined division sharing one divisor
  logic            div_valid;
  logic [InvW-1:0] quo [Lanes];
  tis_meta_t       div_meta;
  logic [InvW-1:0] inv [Lanes];

  tis_divider #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .INV_FRAC_BITS   (INV_FRAC_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (det_valid),
    .dmag_i  (dmag),
    .mag_i   (mag),
    .meta_i  (det_meta),
    .valid_o (div_valid),
    .quo_o   (quo),
    .meta_o  (div_meta)
  );

  // sign and saturation; a quotient of 2^32 or more is flagged as overflow
  for (genvar l = 0; l < Lanes; l++) begin : g_sat
    always_comb begin
      if (div_meta.deg) begin
        inv[l] = '0;
      end else if (div_meta.neg[l]) begin
        if (div_meta.ovf[l] || quo[l] > {1'b1, {(InvW-1){1'b0}}}) begin
          inv[l] = {1'b1, {(InvW-1){1'b0}}};
        end else begin
          inv[l] = -quo[l];
        end
      end else begin
        if (div_meta.ovf[l] || quo[l][InvW-1]) begin
          inv[l] = {1'b0, {(InvW-1){1'b1}}};
        end else begin
          inv[l] = quo[l];
        end
      end
    end
  end

  always_comb begin
    res_d.inv_00      = inv[0];
    res_d.inv_01      = inv[1];
    res_d.inv_02      = inv[2];
    res_d.inv_10      = inv[3];
    res_d.inv_11      = inv[4];
    res_d.inv_12      = inv[5];
    res_d.inv_20      = inv[6];
    res_d.inv_21      = inv[7];
    res_d.inv_22      = inv[8];
    res_d.determinant = div_meta.deg ? '0 : div_meta.det;
    res_d.degenerate  = div_meta.deg;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule
